FILE: hdl/cmpc_pkg.sv
package cmpc_pkg;

   // Cover position codes
   localparam logic [2:0] POS_MIDDLE        = 3'd0;
   localparam logic [2:0] POS_CLOSED        = 3'd1;
   localparam logic [2:0] POS_ALMOST_CLOSED = 3'd2;
   localparam logic [2:0] POS_ALMOST_OPENED = 3'd3;
   localparam logic [2:0] POS_OPENED        = 3'd4;
   localparam logic [2:0] POS_UNDEFINED     = 3'd5;

   // Run status codes
   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_OPENING = 2'd1;
   localparam logic [1:0] ST_CLOSING = 2'd2;

   // Command codes
   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_OPEN  = 2'd1;
   localparam logic [1:0] OP_CLOSE = 2'd2;
   localparam logic [1:0] OP_STOP  = 2'd3;

   // Register indexes
   localparam logic CSR_NORMAL_SPEED = 1'b0;
   localparam logic CSR_SLOW_SPEED   = 1'b1;

   localparam int SPEED_W    = 16;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;

   // Sensor code: opened, almost opened, almost closed, closed (MSB to LSB)
   localparam logic [3:0] SNS_NONE       = 4'h0;
   localparam logic [3:0] SNS_CLOSED     = 4'h1;
   localparam logic [3:0] SNS_CLOSED_ALT = 4'h3;
   localparam logic [3:0] SNS_ALM_CLOSED = 4'h2;
   localparam logic [3:0] SNS_ALM_OPENED = 4'h4;
   localparam logic [3:0] SNS_OPENED     = 4'h8;
   localparam logic [3:0] SNS_OPENED_ALT = 4'hC;

   // Request item, MSB first: closed_sensor ends up in bit 0
   typedef struct packed {
      logic [1:0] op;
      logic       opened_sensor;
      logic       almost_opened_sensor;
      logic       almost_closed_sensor;
      logic       closed_sensor;
   } cmpc_req_type;

   typedef struct packed {
      logic [2:0]         pos_now;
      logic [1:0]         status;
      logic               drive_on;
      logic               drive_ccw;
      logic [SPEED_W-1:0] drive_speed;
   } cmpc_state_type;

   typedef struct packed {
      logic [2:0]         cover_position;
      logic [1:0]         cover_status;
      logic [SPEED_W-1:0] motor_speed;
      logic               motor_direction;
      logic               motor_enable;
   } cmpc_rsp_type;

   function automatic logic [2:0] decode_position(input logic [3:0] code);
      logic [2:0] pos;
      unique case (code)
         SNS_NONE:                       pos = POS_MIDDLE;
         SNS_CLOSED, SNS_CLOSED_ALT:     pos = POS_CLOSED;
         SNS_ALM_CLOSED:                 pos = POS_ALMOST_CLOSED;
         SNS_ALM_OPENED:                 pos = POS_ALMOST_OPENED;
         SNS_OPENED, SNS_OPENED_ALT:     pos = POS_OPENED;
         default:                        pos = POS_UNDEFINED;
      endcase
      return pos;
   endfunction

endpackage

FILE: hdl/cover_motor_position_controller.sv
// Cover motor position controller.
// req_ channel: one item per control tick, carrying the four limit-sensor
// levels and a command (none, open, close, stop). rsp_ channel: one item per
// request item with the motor drive (enable, direction, speed), the run
// status and the decoded cover position after that tick.
// csr_ port: csr_addr 0 writes the normal speed, 1 the slow speed; a write
// takes effect at the clock edge where csr_we is high. Write only while idle.
// A request accepted at one edge shows its result on rsp_ right after that
// edge, unless the receiver is stalling a held result. Throughput: one item
// per cycle while req_tready is high.
// A two-entry result buffer (result register plus skid register) lets one
// more item in while the receiver stalls; req_tready drops only when both
// entries hold results that have not been taken.
// Reset (synchronous, active high) empties the result buffer, sets position
// to undefined, status to idle, removes motor power and clears the speeds.
module cover_motor_position_controller
   import cmpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [0] closed_sensor, [1] almost_closed_sensor, [2] almost_opened_sensor,
   // [3] opened_sensor, [5:4] op, [7:6] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] motor_enable, [1] motor_direction, [17:2] motor_speed,
   // [19:18] cover_status, [22:20] cover_position, [23] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic                  csr_addr,
   input  logic [SPEED_W-1:0]    csr_wdata
);

   logic [SPEED_W-1:0] normal_speed_ff, normal_speed_in;
   logic [SPEED_W-1:0] slow_speed_ff, slow_speed_in;
   cmpc_state_type     state_ff, state_in;
   cmpc_state_type     step_state;
   cmpc_req_type       req_item;
   cmpc_rsp_type       step_rsp;
   cmpc_rsp_type       out_data_ff, out_data_in;
   cmpc_rsp_type       skid_data_ff, skid_data_in;
   logic               out_valid_ff, out_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   logic               req_accept;

   assign req_item = cmpc_req_type'(req_tdata[5:0]);

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;

   cmpc_step u_step (
      .normal_speed (normal_speed_ff),
      .slow_speed   (slow_speed_ff),
      .req          (req_item),
      .st           (state_ff),
      .st_next      (step_state),
      .rsp          (step_rsp)
   );

   // Configuration registers
   always_comb begin
      normal_speed_in = normal_speed_ff;
      slow_speed_in   = slow_speed_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_NORMAL_SPEED: normal_speed_in = csr_wdata;
            CSR_SLOW_SPEED:   slow_speed_in   = csr_wdata;
         endcase
      end
   end

   // Controller state advances once per accepted item
   assign state_in = req_accept ? step_state : state_ff;

   // Result register and skid register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_valid_ff && !rsp_tready) begin
         if (req_accept) begin
            skid_valid_in = 1'b1;
            skid_data_in  = step_rsp;
         end
      end else if (skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end else begin
         out_valid_in = req_accept;
         if (req_accept) begin
            out_data_in = step_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_speed_ff      <= '0;
         slow_speed_ff        <= '0;
         state_ff.pos_now     <= POS_UNDEFINED;
         state_ff.status      <= ST_IDLE;
         state_ff.drive_on    <= 1'b0;
         state_ff.drive_ccw   <= 1'b0;
         state_ff.drive_speed <= '0;
         out_valid_ff         <= 1'b0;
         skid_valid_ff        <= 1'b0;
      end else begin
         normal_speed_ff <= normal_speed_in;
         slow_speed_ff   <= slow_speed_in;
         state_ff        <= state_in;
         out_valid_ff    <= out_valid_in;
         skid_valid_ff   <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_data_ff};

`ifndef NO_ASSERTIONS
   // The skid entry is only ever filled behind a full result register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds an item while result register is empty");

   // An item accepted into an empty buffer is shown the next cycle
   a_accept_shows: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !out_valid_ff) |=> rsp_tvalid)
      else $error("accepted item not presented on result channel");

   // Idle status never leaves the motor powered
   a_idle_unpowered: assert property (@(posedge clock) disable iff (reset)
      (state_ff.status == ST_IDLE) |-> !state_ff.drive_on)
      else $error("motor powered while status is idle");

   // A presented result with power removed carries zero speed
   a_speed_zero_off: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_data_ff.motor_enable) |-> (out_data_ff.motor_speed == '0))
      else $error("nonzero speed with motor disabled");

   // Without an accepted item the controller state holds
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(state_ff))
      else $error("controller state changed without an accepted item");
`endif

endmodule

FILE: hdl/cmpc_step.sv
// Next-state logic for one tick: zone handling, then the command.
module cmpc_step
   import cmpc_pkg::*;
(
   input  logic [SPEED_W-1:0] normal_speed,
   input  logic [SPEED_W-1:0] slow_speed,
   input  cmpc_req_type       req,
   input  cmpc_state_type     st,
   output cmpc_state_type     st_next,
   output cmpc_rsp_type       rsp
);

   logic [2:0] pos_prev;
   logic [2:0] pos_cur;

   assign pos_prev = st.pos_now;
   assign pos_cur  = decode_position({req.opened_sensor, req.almost_opened_sensor,
                                      req.almost_closed_sensor, req.closed_sensor});

   always_comb begin
      st_next         = st;
      st_next.pos_now = pos_cur;

      // Slow-down zone entry and end-zone arrival
      if (st.status == ST_OPENING) begin
         if (pos_prev == POS_MIDDLE && pos_cur == POS_ALMOST_OPENED) begin
            st_next.drive_on    = 1'b1;
            st_next.drive_ccw   = 1'b0;
            st_next.drive_speed = slow_speed;
         end else if (pos_prev == POS_ALMOST_OPENED && pos_cur == POS_OPENED) begin
            st_next.drive_on = 1'b0;
            st_next.status   = ST_IDLE;
         end
      end else if (st.status == ST_CLOSING) begin
         if (pos_prev == POS_MIDDLE && pos_cur == POS_ALMOST_CLOSED) begin
            st_next.drive_on    = 1'b1;
            st_next.drive_ccw   = 1'b1;
            st_next.drive_speed = slow_speed;
         end else if (pos_prev == POS_ALMOST_CLOSED && pos_cur == POS_CLOSED) begin
            st_next.drive_on = 1'b0;
            st_next.status   = ST_IDLE;
         end
      end

      // Command, checked against the status after zone handling
      unique case (req.op)
         OP_OPEN: begin
            if (pos_cur != POS_OPENED && st_next.status != ST_OPENING) begin
               st_next.status = ST_OPENING;
               if (pos_cur == POS_CLOSED || pos_cur == POS_ALMOST_CLOSED ||
                   pos_cur == POS_MIDDLE) begin
                  st_next.drive_on    = 1'b1;
                  st_next.drive_ccw   = 1'b0;
                  st_next.drive_speed = normal_speed;
               end else if (pos_cur == POS_ALMOST_OPENED) begin
                  st_next.drive_on    = 1'b1;
                  st_next.drive_ccw   = 1'b0;
                  st_next.drive_speed = slow_speed;
               end else begin
                  st_next.drive_on = 1'b0;
               end
            end
         end
         OP_CLOSE: begin
            if (pos_cur != POS_CLOSED && st_next.status != ST_CLOSING) begin
               st_next.status = ST_CLOSING;
               if (pos_cur == POS_OPENED || pos_cur == POS_ALMOST_OPENED ||
                   pos_cur == POS_MIDDLE) begin
                  st_next.drive_on    = 1'b1;
                  st_next.drive_ccw   = 1'b1;
                  st_next.drive_speed = normal_speed;
               end else if (pos_cur == POS_ALMOST_CLOSED) begin
                  st_next.drive_on    = 1'b1;
                  st_next.drive_ccw   = 1'b1;
                  st_next.drive_speed = slow_speed;
               end else begin
                  st_next.drive_on = 1'b0;
               end
            end
         end
         OP_STOP: begin
            if (st_next.status != ST_IDLE) begin
               st_next.status   = ST_IDLE;
               st_next.drive_on = 1'b0;
            end
         end
         OP_NONE: begin
         end
      endcase
   end

   // Result item taken from the updated state
   always_comb begin
      rsp.motor_enable    = st_next.drive_on;
      rsp.motor_direction = st_next.drive_ccw;
      rsp.motor_speed     = st_next.drive_on ? st_next.drive_speed : '0;
      rsp.cover_status    = st_next.status;
      rsp.cover_position  = st_next.pos_now;
   end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb
   import cmpc_pkg::*;
();

   localparam int HOLD_CYCLES  = 80;
   localparam int IDLE_LIMIT   = 2000;
   localparam int REPORT_LIMIT = 10;

   // Track positions used to steer the simulated cover
   localparam int TRK_CLOSED     = 0;
   localparam int TRK_ALM_CLOSED = 1;
   localparam int TRK_MIDDLE     = 2;
   localparam int TRK_ALM_OPENED = 3;
   localparam int TRK_OPENED     = 4;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // [0] closed, [1] almost closed, [2] almost opened, [3] opened, [5:4] op, [7:6] zero
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [0] enable, [1] direction, [17:2] speed, [19:18] status, [22:20] position, [23] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic                  csr_addr;
   logic [SPEED_W-1:0]    csr_wdata;

   cover_motor_position_controller u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Controller shadow state
   logic [2:0]         mdl_pos;
   logic [2:0]         mdl_prev;
   logic [1:0]         mdl_status;
   logic               mdl_on;
   logic               mdl_ccw;
   logic [SPEED_W-1:0] mdl_speed;
   logic [SPEED_W-1:0] mdl_normal;
   logic [SPEED_W-1:0] mdl_slow;

   cmpc_rsp_type drive_q[$];
   int           mismatch_count;
   int           burst_left;
   int           track_pos;
   int           idle_cycles;
   bit           hold_req;

   always #1 clock = ~clock;

   // Sensor pattern to cover position
   function automatic logic [2:0] sensor_to_pos(input logic [3:0] sns);
      logic [2:0] pos;
      pos = POS_UNDEFINED;
      if (sns == SNS_NONE)
         pos = POS_MIDDLE;
      else if (sns[3:2] == 2'b00 && sns[0])
         pos = POS_CLOSED;
      else if (sns == SNS_ALM_CLOSED)
         pos = POS_ALMOST_CLOSED;
      else if (sns == SNS_ALM_OPENED)
         pos = POS_ALMOST_OPENED;
      else if (sns[3] && sns[1:0] == 2'b00)
         pos = POS_OPENED;
      return pos;
   endfunction

   function automatic void run_motor(input logic ccw, input logic [SPEED_W-1:0] spd);
      mdl_on    = 1'b1;
      mdl_ccw   = ccw;
      mdl_speed = spd;
   endfunction

   // One control tick: zone transitions, then the command, then queue the drive
   function automatic void predict_drive(input logic [3:0] sns, input logic [1:0] op);
      cmpc_rsp_type r;
      mdl_prev = mdl_pos;
      mdl_pos  = sensor_to_pos(sns);
      if (mdl_status == ST_OPENING) begin
         if (mdl_prev == POS_MIDDLE && mdl_pos == POS_ALMOST_OPENED)
            run_motor(1'b0, mdl_slow);
         else if (mdl_prev == POS_ALMOST_OPENED && mdl_pos == POS_OPENED) begin
            mdl_on     = 1'b0;
            mdl_status = ST_IDLE;
         end
      end else if (mdl_status == ST_CLOSING) begin
         if (mdl_prev == POS_MIDDLE && mdl_pos == POS_ALMOST_CLOSED)
            run_motor(1'b1, mdl_slow);
         else if (mdl_prev == POS_ALMOST_CLOSED && mdl_pos == POS_CLOSED) begin
            mdl_on     = 1'b0;
            mdl_status = ST_IDLE;
         end
      end
      case (op)
         OP_OPEN: begin
            if (mdl_pos != POS_OPENED && mdl_status != ST_OPENING) begin
               mdl_status = ST_OPENING;
               if (mdl_pos == POS_ALMOST_OPENED)
                  run_motor(1'b0, mdl_slow);
               else if (mdl_pos == POS_UNDEFINED)
                  mdl_on = 1'b0;
               else
                  run_motor(1'b0, mdl_normal);
            end
         end
         OP_CLOSE: begin
            if (mdl_pos != POS_CLOSED && mdl_status != ST_CLOSING) begin
               mdl_status = ST_CLOSING;
               if (mdl_pos == POS_ALMOST_CLOSED)
                  run_motor(1'b1, mdl_slow);
               else if (mdl_pos == POS_UNDEFINED)
                  mdl_on = 1'b0;
               else
                  run_motor(1'b1, mdl_normal);
            end
         end
         OP_STOP: begin
            if (mdl_status != ST_IDLE) begin
               mdl_status = ST_IDLE;
               mdl_on     = 1'b0;
            end
         end
         default: ;
      endcase
      r.motor_enable    = mdl_on;
      r.motor_direction = mdl_ccw;
      r.motor_speed     = mdl_on ? mdl_speed : '0;
      r.cover_status    = mdl_status;
      r.cover_position  = mdl_pos;
      drive_q.push_back(r);
   endfunction

   // Offer one item, in bursts separated by random gaps
   task automatic send_item(input logic [3:0] sns, input logic [1:0] op);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {2'b00, op, sns};
      do @(posedge clock); while (!req_tready);
      predict_drive(sns, op);
   endtask

   // Stop offering and wait for every outstanding drive result
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (drive_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_speed(input logic addr, input logic [SPEED_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = addr;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (addr == CSR_NORMAL_SPEED)
         mdl_normal = value;
      else
         mdl_slow = value;
   endtask

   task automatic set_speeds(input logic [SPEED_W-1:0] norm, input logic [SPEED_W-1:0] slow);
      settle();
      write_speed(CSR_NORMAL_SPEED, norm);
      write_speed(CSR_SLOW_SPEED, slow);
   endtask

   function automatic logic [3:0] track_sensors(input int trk);
      logic [3:0] sns;
      case (trk)
         TRK_CLOSED:     sns = $urandom_range(0, 1) ? SNS_CLOSED_ALT : SNS_CLOSED;
         TRK_ALM_CLOSED: sns = SNS_ALM_CLOSED;
         TRK_MIDDLE:     sns = SNS_NONE;
         TRK_ALM_OPENED: sns = SNS_ALM_OPENED;
         default:        sns = $urandom_range(0, 1) ? SNS_OPENED_ALT : SNS_OPENED;
      endcase
      return sns;
   endfunction

   // Cover travel along the track following the drive, with commands and sensor noise
   task automatic run_travel(input int count);
      int         roll;
      logic [3:0] sns;
      logic [1:0] op;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (mdl_on && mdl_status != ST_IDLE && roll < 55) begin
            if (!mdl_ccw && track_pos < TRK_OPENED)
               track_pos++;
            else if (mdl_ccw && track_pos > TRK_CLOSED)
               track_pos--;
         end else if (roll >= 95) begin
            track_pos = $urandom_range(TRK_CLOSED, TRK_OPENED);
         end
         if ($urandom_range(0, 99) < 8)
            sns = 4'($urandom_range(0, 15));
         else
            sns = track_sensors(track_pos);
         roll = $urandom_range(0, 99);
         if (roll < 68)
            op = OP_NONE;
         else if (roll < 79)
            op = OP_OPEN;
         else if (roll < 90)
            op = OP_CLOSE;
         else
            op = OP_STOP;
         send_item(sns, op);
      end
   endtask

   // Every command and every special case, plus all sixteen sensor patterns
   task automatic test_directed();
      set_speeds(16'h1234, 16'h0056);
      send_item(4'b0101, OP_OPEN);       // start from undefined
      send_item(SNS_NONE, OP_NONE);
      send_item(SNS_ALM_OPENED, OP_NONE); // slow-down zone entry
      send_item(SNS_OPENED, OP_NONE);     // end-zone arrival
      send_item(SNS_OPENED_ALT, OP_OPEN); // open refused at opened
      send_item(SNS_OPENED_ALT, OP_STOP); // stop while idle
      send_item(SNS_OPENED_ALT, OP_CLOSE);
      send_item(SNS_ALM_OPENED, OP_CLOSE); // close refused, already closing
      send_item(SNS_NONE, OP_NONE);
      send_item(SNS_ALM_CLOSED, OP_NONE);
      send_item(SNS_CLOSED_ALT, OP_NONE);
      send_item(SNS_CLOSED, OP_CLOSE);    // close refused at closed
      send_item(SNS_CLOSED, OP_OPEN);
      send_item(SNS_ALM_CLOSED, OP_STOP);
      send_item(SNS_ALM_CLOSED, OP_CLOSE); // start inside slow zone
      send_item(SNS_ALM_OPENED, OP_OPEN);  // reverse inside slow zone
      send_item(4'b0110, OP_NONE);
      send_item(4'b0111, OP_CLOSE);
      send_item(4'b1001, OP_OPEN);
      send_item(4'b1010, OP_STOP);
      send_item(4'b1011, OP_CLOSE);
      send_item(4'b1101, OP_NONE);
      send_item(4'b1110, OP_OPEN);
      send_item(4'b1111, OP_STOP);
   endtask

   // Extreme register settings with normal travel
   task automatic test_speed_extremes();
      set_speeds(16'hFFFF, 16'h0000);
      run_travel(40);
      set_speeds(16'h0000, 16'hFFFF);
      run_travel(40);
      set_speeds(16'hFFFF, 16'hFFFF);
      run_travel(40);
      set_speeds(16'h0000, 16'h0000);
      run_travel(40);
   endtask

   // Receiver holds off while items keep coming, so the input stalls
   task automatic test_backpressure();
      set_speeds(16'hA5A5, 16'h5A5A);
      hold_req = 1'b1;
      burst_left = 30;
      run_travel(24);
   endtask

   task automatic test_random();
      repeat (5) begin
         set_speeds(16'($urandom), 16'($urandom));
         run_travel(250);
      end
   endtask

   // Receiver stall pattern: modes of random length, including always-ready stretches
   initial begin
      int mode;
      int mode_left;
      int phase;
      rsp_tready = 1'b0;
      mode = 0;
      mode_left = 0;
      phase = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            phase++;
            case (mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = ($urandom_range(0, 3) != 0);
               2: rsp_tready = ($urandom_range(0, 9) < 3);
               default: rsp_tready = (phase % 3 != 0);
            endcase
         end
      end
   end

   // Compare each result with the oldest expected drive
   always @(posedge clock) begin
      cmpc_rsp_type exp_r;
      cmpc_rsp_type act_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         act_r = rsp_tdata[22:0];
         if (drive_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result %h", rsp_tdata);
         end else begin
            exp_r = drive_q.pop_front();
            if (act_r.motor_enable != exp_r.motor_enable ||
                  act_r.motor_direction != exp_r.motor_direction ||
                  act_r.motor_speed != exp_r.motor_speed ||
                  act_r.cover_status != exp_r.cover_status ||
                  act_r.cover_position != exp_r.cover_position) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("mismatch: exp en=%0d dir=%0d spd=%h st=%0d pos=%0d",
                     exp_r.motor_enable, exp_r.motor_direction, exp_r.motor_speed,
                     exp_r.cover_status, exp_r.cover_position);
                  $display("          got en=%0d dir=%0d spd=%h st=%0d pos=%0d",
                     act_r.motor_enable, act_r.motor_direction, act_r.motor_speed,
                     act_r.cover_status, act_r.cover_position);
               end
            end
         end
      end
   end

   // Watchdog: cycles with no item moving on either channel and no register write
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = CSR_NORMAL_SPEED;
      csr_wdata = '0;
      hold_req = 1'b0;
      idle_cycles = 0;
      mismatch_count = 0;
      burst_left = 0;
      track_pos = TRK_MIDDLE;
      mdl_pos = POS_UNDEFINED;
      mdl_prev = POS_UNDEFINED;
      mdl_status = ST_IDLE;
      mdl_on = 1'b0;
      mdl_ccw = 1'b0;
      mdl_speed = '0;
      mdl_normal = '0;
      mdl_slow = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_speed_extremes();
      test_backpressure();
      test_random();
      settle();
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && drive_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: files.f
hdl/cmpc_pkg.sv
hdl/cmpc_step.sv
hdl/cover_motor_position_controller.sv
dv/tb.sv
